/* design/pes_pkg.sv */
// Shared types and constants for the parenthesized expression stack evaluator.
// No dependencies; every other design file but pes_ram imports this package.
package pes_pkg;

    localparam int STACK_DEPTH  = 64;   // token stack entries
    localparam int VALUE_WIDTH  = 32;   // arithmetic width, wraps
    localparam int CACHE_DEPTH  = 8;    // top-of-stack entries held in flops (power of two)
    localparam int QUEUE_DEPTH  = 2;    // front-to-back token queue (power of two)
    localparam int REDUCE_DEPTH = 4;    // entries a close paren consumes

    localparam int KIND_W   = 3;
    localparam int TOKEN_W  = 32;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 2;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int CACHE_IW = $clog2(CACHE_DEPTH);
    localparam int FILL_W   = $clog2(CACHE_DEPTH + 1);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = ((KIND_W + TOKEN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + STATUS_W + 7) / 8) * 8;

    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN    = 3'd0,
        KIND_CLOSE   = 3'd1,
        KIND_NUM     = 3'd2,
        KIND_PLUS    = 3'd3,
        KIND_MINUS   = 3'd4,
        KIND_TIMES   = 3'd5,
        KIND_INVALID = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_LEXICAL = 2'd2
    } t_status;

    // one token stack entry
    typedef struct packed {
        t_kind kind;
        t_val  value;
    } t_entry;

    // classified token handed from front to back
    typedef struct packed {
        logic  push;     // open paren, number or operator
        logic  reduce;   // close paren
        logic  bad;      // lexical error
        t_kind kind;
        t_val  value;
        logic  last;
    } t_tok;

endpackage

/* design/paren_expr_stack_evaluator_core.sv */
// Top level of the fully parenthesized expression stack evaluator.
// Depends on pes_pkg, pes_front, pes_back (which holds pes_ram).

// Evaluates fully parenthesized integer expressions from a stream of
// pre-classified tokens, one token per request on the slave side. Open
// parens, numbers and operators are pushed; a close paren reduces the top
// four entries to a number (wrapping 32-bit add, subtract, multiply). The
// first error is sticky; the request marked tlast produces one result
// request carrying the value and status (0 ok, 1 syntax, 2 lexical).
// Throughput is one token per cycle when the back end does not stall. The top
// eight stack entries live in flops and the rest spill to a RAM with one
// access per cycle, so a close paren waits while fewer than four entries
// are cached (refill brings back one entry per cycle), and a last token on a
// shallow stack waits for the spilled entries. The result is registered in
// the result register when its last token is accepted; a two-entry queue
// and the result register let each side stall alone.
module paren_expr_stack_evaluator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pes_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [2:0] token_kind, [34:3] token_value
    input  logic                          s_axis_tlast,   // end_of_expr
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pes_pkg::M_TDATA_W-1:0] m_axis_tdata    // [31:0] expr_value, [33:32] status
);
    import pes_pkg::*;

    logic w_tok_valid;
    logic w_tok_ready;
    t_tok w_tok;

    // classification and token queue
    pes_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_tok_valid   (w_tok_valid),
        .i_tok_ready   (w_tok_ready),
        .o_tok         (w_tok)
    );

    // stack, ALU and result register
    pes_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (w_tok_valid),
        .o_tok_ready   (w_tok_ready),
        .i_tok         (w_tok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* design/pes_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pes_front.sv */
// Front end: takes token requests from the input stream, classifies them
// and queues them for the back end. Depends on pes_pkg.
module pes_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pes_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [2:0] token_kind, [34:3] token_value
    input  logic                           s_axis_tlast,   // end_of_expr
    output logic                           o_tok_valid,
    input  logic                           i_tok_ready,
    output pes_pkg::t_tok                  o_tok
);
    import pes_pkg::*;

    logic [KIND_W-1:0]        w_kind_raw;
    logic signed [TOKEN_W-1:0] w_raw_val;
    t_tok                     w_tok;
    logic                     w_push;
    logic                     w_pop;

    t_tok                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QCNT_W-1:0]   r_q_cnt;

    assign w_kind_raw = s_axis_tdata[KIND_W-1:0];
    assign w_raw_val  = s_axis_tdata[KIND_W +: TOKEN_W];

    // classify
    always_comb begin
        w_tok        = '0;
        w_tok.value  = t_val'(w_raw_val);
        w_tok.last   = s_axis_tlast;
        w_tok.kind   = KIND_INVALID;
        unique case (w_kind_raw) inside
            KIND_OPEN, KIND_NUM, KIND_PLUS, KIND_MINUS, KIND_TIMES: begin
                w_tok.push = 1'b1;
                w_tok.kind = t_kind'(w_kind_raw);
            end
            KIND_CLOSE: begin
                w_tok.reduce = 1'b1;
                w_tok.kind   = KIND_CLOSE;
            end
            default: begin
                w_tok.bad = 1'b1;
            end
        endcase
    end

    assign s_axis_tready = (r_q_cnt != QCNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_tok_valid   = (r_q_cnt != '0);
    assign o_tok         = r_q[r_rd_ptr];
    assign w_pop         = o_tok_valid && i_tok_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_q_cnt <= r_q_cnt + 1'b1;
                2'b01:   r_q_cnt <= r_q_cnt - 1'b1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

endmodule

/* design/pes_back.sv */
// Back end: token stack with a flop cache of the top entries over a spill RAM,
// the reduce ALU, sticky error and the result register. Depends on pes_pkg, pes_ram.
module pes_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    output logic                          o_tok_ready,
    input  pes_pkg::t_tok                 i_tok,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pes_pkg::M_TDATA_W-1:0] m_axis_tdata    // [31:0] expr_value, [33:32] status
);
    import pes_pkg::*;

    // cache: entry 0 is top of stack
    t_entry               r_cache [CACHE_DEPTH];
    logic [FILL_W-1:0]    r_fill;
    logic [CNT_W-1:0]     r_below;     // entries held in RAM
    logic                 r_inflight;  // refill read returns this cycle
    logic [CNT_W-1:0]     r_count;
    t_status              r_err;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_value;
    t_status              r_out_status;

    t_entry               n_cache [CACHE_DEPTH];
    logic [FILL_W-1:0]    n_fill;
    logic [CNT_W-1:0]     n_below;
    logic                 n_inflight;
    logic [CNT_W-1:0]     n_count;
    t_status              n_err;

    t_entry               w_c1 [CACHE_DEPTH];
    logic [FILL_W-1:0]    w_f1;
    logic                 w_ok;
    logic                 w_out_free;
    logic                 w_stall_red;
    logic                 w_stall_last;
    logic                 w_take;
    logic                 w_form_ok;
    t_val                 w_alu;
    logic                 w_spill;
    logic                 w_clear;
    logic [CNT_W-1:0]     w_below_dec;
    logic                 w_rd_en;
    logic [STACK_AW-1:0]  w_rd_addr;
    t_entry               w_rd_data;
    logic [OUT_W-1:0]     w_res_value;
    t_status              w_res_status;

    function automatic t_val alu(input t_val a, input t_val b, input t_kind op);
        t_val r;
        case (op)
            KIND_PLUS:  r = a + b;
            KIND_MINUS: r = a - b;
            default:    r = a * b;
        endcase
        return r;
    endfunction

    // refill data lands below the cached entries before the token is applied
    always_comb begin
        w_c1 = r_cache;
        w_f1 = r_fill;
        if (r_inflight) begin
            w_c1[r_fill[CACHE_IW-1:0]] = w_rd_data;
            w_f1 = r_fill + 1'b1;
        end
    end

    assign w_ok       = (r_err == ST_OK);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // close paren needs the top four entries in flops
    assign w_stall_red = i_tok.reduce && w_ok && (r_count >= CNT_W'(REDUCE_DEPTH)) &&
                         (w_f1 < FILL_W'(REDUCE_DEPTH));
    // last token: result register must be free; a shallow stack must be fully cached
    assign w_stall_last = i_tok.last &&
                          (!w_out_free ||
                           (w_ok && (r_count <= CNT_W'(REDUCE_DEPTH)) && (r_below != '0)));
    assign o_tok_ready = !w_stall_red && !w_stall_last;
    assign w_take      = i_tok_valid && o_tok_ready;

    assign w_form_ok = (w_c1[0].kind == KIND_NUM) && (w_c1[2].kind == KIND_NUM) &&
                       (w_c1[3].kind == KIND_OPEN) &&
                       ((w_c1[1].kind == KIND_PLUS) || (w_c1[1].kind == KIND_MINUS) ||
                        (w_c1[1].kind == KIND_TIMES));
    assign w_alu = alu(w_c1[2].value, w_c1[0].value, w_c1[1].kind);

    always_comb begin
        n_cache      = w_c1;
        n_fill       = w_f1;
        n_below      = r_below;
        n_count      = r_count;
        n_err        = r_err;
        n_inflight   = 1'b0;
        w_spill      = 1'b0;
        w_clear      = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_below_dec  = '0;
        w_res_value  = '0;
        w_res_status = ST_OK;

        if (w_take && w_ok) begin
            if (i_tok.bad) begin
                n_err = ST_LEXICAL;
            end else if (i_tok.push) begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    n_err = ST_SYNTAX;
                end else begin
                    // full cache: bottom entry goes to RAM
                    if (w_f1 == FILL_W'(CACHE_DEPTH)) begin
                        w_spill = 1'b1;
                        n_below = r_below + 1'b1;
                    end else begin
                        n_fill = w_f1 + 1'b1;
                    end
                    for (int i = CACHE_DEPTH - 1; i > 0; i--) begin
                        n_cache[i] = w_c1[i-1];
                    end
                    n_cache[0].kind  = i_tok.kind;
                    n_cache[0].value = i_tok.value;
                    n_count = r_count + 1'b1;
                end
            end else if (i_tok.reduce) begin
                if ((r_count < CNT_W'(REDUCE_DEPTH)) || !w_form_ok) begin
                    n_err = ST_SYNTAX;
                end else begin
                    n_cache[0].kind  = KIND_NUM;
                    n_cache[0].value = w_alu;
                    for (int i = 1; i < CACHE_DEPTH - REDUCE_DEPTH + 1; i++) begin
                        n_cache[i] = w_c1[i + REDUCE_DEPTH - 1];
                    end
                    n_fill  = w_f1 - FILL_W'(REDUCE_DEPTH - 1);
                    n_count = r_count - CNT_W'(REDUCE_DEPTH - 1);
                end
            end
        end

        // result and end-of-expression clear
        if (w_take && i_tok.last) begin
            w_clear      = 1'b1;
            w_res_status = n_err;
            if (n_err == ST_OK) begin
                if ((n_count == CNT_W'(1)) && (n_cache[0].kind == KIND_NUM)) begin
                    w_res_value = OUT_W'($signed(n_cache[0].value));
                end else begin
                    w_res_status = ST_SYNTAX;
                end
            end
            n_count = '0;
            n_fill  = '0;
            n_below = '0;
            n_err   = ST_OK;
        end

        // keep the cache topped up from RAM, one entry per cycle unless a spill or clear holds it
        if (!w_spill && !w_clear && (n_fill <= FILL_W'(CACHE_DEPTH - 2)) &&
            (n_below != '0)) begin
            w_below_dec = n_below - 1'b1;
            w_rd_en     = 1'b1;
            w_rd_addr   = w_below_dec[STACK_AW-1:0];
            n_below     = w_below_dec;
            n_inflight  = 1'b1;
        end
    end

    pes_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_spill_ram (
        .i_clk   (i_clk),
        .i_we    (w_spill),
        .i_waddr (r_below[STACK_AW-1:0]),
        .i_wdata (w_c1[CACHE_DEPTH-1]),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_cache <= n_cache;
        if (w_clear) begin
            r_out_value  <= w_res_value;
            r_out_status <= w_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_below     <= '0;
            r_inflight  <= 1'b0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_below    <= n_below;
            r_inflight <= n_inflight;
            r_count    <= n_count;
            r_err      <= n_err;
            if (w_clear) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_status, r_out_value});

    // stack bookkeeping: every entry is cached, in flight or spilled
    a_count_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == r_below + CNT_W'(r_inflight) + CNT_W'(r_fill))
        else $error("stack count does not match cache, refill and RAM");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(CACHE_DEPTH)) && (r_count <= CNT_W'(STACK_DEPTH)))
        else $error("cache fill or stack count out of range");

    a_no_spill_on_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> !w_spill)
        else $error("spill collides with returning refill");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_tok.last) |=> (r_out_valid && (r_count == '0) && !r_inflight &&
                                    (r_err == ST_OK)))
        else $error("end of expression did not post a result and clear");

endmodule
